// File: src/dlds_pkg.sv
// Shared types and constants for the daily light dimming scheduler.
// No dependencies; every other file of the block refers to this package.
package dlds_pkg;

    localparam int MinPerHour  = 60;
    localparam int HoursPerDay = 24;
    localparam int MinPerDay   = 1440;
    localparam int FullLevel   = 255;

    localparam int HourW   = 5;
    localparam int MinuteW = 6;
    localparam int TimeW   = 11;
    localparam int RampW   = 10;
    localparam int LevelW  = 8;
    localparam int NumW    = RampW + LevelW;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 10;

    localparam logic [CfgIdxW-1:0] CFG_ENABLE     = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_ON_HOUR    = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_ON_MINUTE  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_OFF_HOUR   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_OFF_MINUTE = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_RAMP       = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_STEP       = 3'd6;

    localparam logic [RampW-1:0]  RampReset = 10'd30;
    localparam logic [LevelW-1:0] StepReset = 8'd10;

    typedef struct packed {
        logic [HourW-1:0]   hour;
        logic [MinuteW-1:0] minute;
    } in_word_t;

    typedef struct packed {
        logic [LevelW-1:0] level;
        logic              light_on;
    } out_word_t;

    typedef struct packed {
        logic load_time;
        logic load_window;
        logic load_target;
        logic div_start;
        logic commit;
    } dlds_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } dlds_sts_t;

endpackage

// File: src/dlds_div.sv
// Restoring divider: 18-bit numerator by 10-bit ramp length, 8-bit quotient.
// One quotient bit per cycle. Depends on dlds_pkg.
module dlds_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [dlds_pkg::NumW-1:0]      num,
    input  logic [dlds_pkg::RampW-1:0]     den,
    output logic                           done,
    output logic [dlds_pkg::LevelW-1:0]    quo
);

    logic [dlds_pkg::NumW-1:0]   rem_reg, rem_next;
    logic [dlds_pkg::NumW-1:0]   dsh_reg, dsh_next;
    logic [dlds_pkg::LevelW-1:0] quo_reg, quo_next;
    logic [2:0]                  cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic                        ge;

    assign ge = (rem_reg >= dsh_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            dsh_next  = {1'b0, den, 7'b0};
            cnt_next  = 3'd7;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            quo_next = {quo_reg[dlds_pkg::LevelW-2:0], ge};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 3'd1;
            if (cnt_reg == 3'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not start");

    a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> done_reg)
        else $error("divider stopped without done");

endmodule

// File: src/dlds_dp.sv
// Datapath: configuration registers, time and window arithmetic, fade
// division, slew limiting and the output word. Depends on dlds_pkg, dlds_div.
module dlds_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dlds_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [dlds_pkg::CfgDataW-1:0]    cfg_data,
    input  dlds_pkg::in_word_t               in_data,
    input  dlds_pkg::dlds_cmd_t              cmd,
    output dlds_pkg::dlds_sts_t              sts,
    output dlds_pkg::out_word_t              out_data
);

    localparam int TW = dlds_pkg::TimeW;
    localparam int LW = dlds_pkg::LevelW;
    localparam logic [TW:0]   DayW    = (TW+1)'(dlds_pkg::MinPerDay);
    localparam logic [LW-1:0] FullLvl = LW'(dlds_pkg::FullLevel);

    function automatic logic [TW-1:0] time_of(
        input logic [dlds_pkg::HourW-1:0]   h,
        input logic [dlds_pkg::MinuteW-1:0] m
    );
        logic [TW-1:0] t;
        t = {h, 6'b0} - {4'b0, h, 2'b0} + {5'b0, m};
        if ({1'b0, t} >= DayW)
        begin
            t = t - DayW[TW-1:0];
        end
        return t;
    endfunction

    function automatic logic [TW-1:0] wrap_diff(
        input logic [TW-1:0] a,
        input logic [TW-1:0] b
    );
        logic [TW:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (a < b)
        begin
            d = d + DayW;
        end
        return d[TW-1:0];
    endfunction

    logic                           enable_reg;
    logic [dlds_pkg::HourW-1:0]     on_hour_reg, off_hour_reg;
    logic [dlds_pkg::MinuteW-1:0]   on_min_reg, off_min_reg;
    logic [dlds_pkg::RampW-1:0]     ramp_reg;
    logic [LW-1:0]                  step_reg;
    logic [LW-1:0]                  level_reg, level_next;
    logic [TW-1:0]                  now_reg, len_reg, el_reg;
    logic [LW-1:0]                  target_reg;
    logic                           need_div_reg;

    dlds_pkg::out_word_t            out_reg;

    logic [dlds_pkg::HourW-1:0]     hour_mod;
    logic [dlds_pkg::MinuteW-1:0]   min_mod;
    logic [TW-1:0]                  t_on, t_off, len_ramp;
    logic [TW:0]                    ramp2;
    logic [LW-1:0]                  target_now, target_sel;
    logic                           need_div_now;
    logic [dlds_pkg::RampW-1:0]     div_x;
    logic [dlds_pkg::NumW-1:0]      div_num;
    logic                           div_done;
    logic [LW-1:0]                  div_quo;

    assign hour_mod = (cfg_data[4:0] >= 5'(dlds_pkg::HoursPerDay))
                      ? cfg_data[4:0] - 5'(dlds_pkg::HoursPerDay) : cfg_data[4:0];
    assign min_mod  = (cfg_data[5:0] >= 6'(dlds_pkg::MinPerHour))
                      ? cfg_data[5:0] - 6'(dlds_pkg::MinPerHour) : cfg_data[5:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            on_hour_reg  <= '0;
            on_min_reg   <= '0;
            off_hour_reg <= '0;
            off_min_reg  <= '0;
            ramp_reg     <= dlds_pkg::RampReset;
            step_reg     <= dlds_pkg::StepReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dlds_pkg::CFG_ENABLE:     enable_reg   <= cfg_data[0];
                dlds_pkg::CFG_ON_HOUR:    on_hour_reg  <= hour_mod;
                dlds_pkg::CFG_ON_MINUTE:  on_min_reg   <= min_mod;
                dlds_pkg::CFG_OFF_HOUR:   off_hour_reg <= hour_mod;
                dlds_pkg::CFG_OFF_MINUTE: off_min_reg  <= min_mod;
                dlds_pkg::CFG_RAMP:       ramp_reg     <= cfg_data[dlds_pkg::RampW-1:0];
                dlds_pkg::CFG_STEP:       step_reg     <= cfg_data[LW-1:0];
                default:                  ;
            endcase
        end
    end

    assign t_on     = time_of(on_hour_reg, on_min_reg);
    assign t_off    = time_of(off_hour_reg, off_min_reg);
    assign ramp2    = {1'b0, ramp_reg, 1'b0};
    assign len_ramp = len_reg - {1'b0, ramp_reg};

    always_comb
    begin
        target_now   = '0;
        need_div_now = 1'b0;
        div_x        = el_reg[dlds_pkg::RampW-1:0];
        if (!enable_reg || el_reg >= len_reg)
        begin
            target_now = '0;
        end
        else if ({1'b0, len_reg} <= ramp2)
        begin
            target_now = FullLvl;
        end
        else if (el_reg < {1'b0, ramp_reg})
        begin
            need_div_now = 1'b1;
        end
        else if (el_reg < len_ramp)
        begin
            target_now = FullLvl;
        end
        else
        begin
            need_div_now = 1'b1;
            div_x        = 10'(len_reg - el_reg);
        end
    end

    assign div_num = {div_x, 8'b0} - {8'b0, div_x};

    dlds_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (ramp_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_time)
        begin
            now_reg <= time_of(in_data.hour, in_data.minute);
        end
        if (cmd.load_window)
        begin
            len_reg <= wrap_diff(t_off, t_on);
            el_reg  <= wrap_diff(now_reg, t_on);
        end
        if (cmd.load_target)
        begin
            target_reg   <= target_now;
            need_div_reg <= need_div_now;
        end
        if (cmd.commit)
        begin
            out_reg.level    <= level_next;
            out_reg.light_on <= (level_next != '0);
        end
    end

    assign target_sel = need_div_reg ? div_quo : target_reg;

    always_comb
    begin
        level_next = level_reg;
        if (target_sel > level_reg)
        begin
            if (target_sel - level_reg > step_reg)
            begin
                level_next = level_reg + step_reg;
            end
            else
            begin
                level_next = target_sel;
            end
        end
        else if (level_reg > target_sel)
        begin
            if (level_reg - target_sel > step_reg)
            begin
                level_next = level_reg - step_reg;
            end
            else
            begin
                level_next = target_sel;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else if (cfg_we && cfg_index == dlds_pkg::CFG_ENABLE && !cfg_data[0])
        begin
            level_reg <= '0;
        end
        else if (cmd.commit)
        begin
            level_reg <= level_next;
        end
    end

    assign sts.need_div = need_div_now;
    assign sts.div_done = div_done;
    assign out_data     = out_reg;

endmodule

// File: src/dlds_ctrl.sv
// Controller: steps one tick through window, target, optional division and commit,
// and owns both handshakes. Depends on dlds_pkg.
module dlds_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  dlds_pkg::dlds_sts_t   sts,
    output dlds_pkg::dlds_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WINDOW,
        S_TARGET,
        S_DIVIDE,
        S_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_time = 1'b1;
                    state_next    = S_WINDOW;
                end
            end
            S_WINDOW:
            begin
                cmd.load_window = 1'b1;
                state_next      = S_TARGET;
            end
            S_TARGET:
            begin
                cmd.load_target = 1'b1;
                if (sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVIDE;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_DIVIDE:
            begin
                if (sts.div_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed word not presented");

    a_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> state_reg == S_DIVIDE)
        else $error("divider finished outside divide state");

    a_accept_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_time |=> state_reg == S_WINDOW && in_stall)
        else $error("accepted tick not in progress");

endmodule

// File: src/daily_light_dimming_scheduler.sv
// Top level of the daily light dimming scheduler: controller plus datapath.
// Depends on dlds_pkg, dlds_ctrl, dlds_dp (which holds dlds_div).
//
//   channel  direction  handshake           word
//   in       input      in_valid/in_stall    in_data  (hour, minute)
//   out      output     out_valid/out_stall  out_data (level, light_on)
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// From acceptance to a valid output word, a tick goes through the window, target
// and commit steps, and during a fade also through the 8-step ramp divider.
// A new tick is taken once the previous word is loaded into the output register.
// Reset clears the level and loads register defaults; no clearing pass.
// A stalled output holds its word; the next tick then waits in its commit step.
module daily_light_dimming_scheduler (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  dlds_pkg::in_word_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output dlds_pkg::out_word_t            out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dlds_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [dlds_pkg::CfgDataW-1:0]  cfg_data
);

    dlds_pkg::dlds_cmd_t cmd;
    dlds_pkg::dlds_sts_t sts;

    assign cfg_ready = 1'b1;

    dlds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    dlds_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (out_data)
    );

endmodule

// File: tb/tb_daily_light_dimming_scheduler.sv
// Testbench for daily_light_dimming_scheduler: directed and random ticks checked
// against a cycle-free predictor of the schedule and slew limiter.
// Depends on dlds_pkg and the block's top level.
module tb_daily_light_dimming_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HourW       = dlds_pkg::HourW;
    localparam int MinuteW     = dlds_pkg::MinuteW;
    localparam int RampW       = dlds_pkg::RampW;
    localparam int LevelW      = dlds_pkg::LevelW;
    localparam int CfgIdxW     = dlds_pkg::CfgIdxW;
    localparam int CfgDataW    = dlds_pkg::CfgDataW;
    localparam int MinPerHour  = dlds_pkg::MinPerHour;
    localparam int HoursPerDay = dlds_pkg::HoursPerDay;
    localparam int MinPerDay   = dlds_pkg::MinPerDay;
    localparam int FullLevel   = dlds_pkg::FullLevel;

    localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;
    localparam int SettleCycles = 16;
    localparam int DrainLimit   = 5000;

    localparam int PickRaw  = 0;
    localparam int PickEdge = 1;
    localparam int PickWalk = 2;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    dlds_pkg::in_word_t  in_data;
    logic                out_valid;
    logic                out_stall;
    dlds_pkg::out_word_t out_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    logic              sch_en;
    logic [HourW-1:0]  on_h;
    logic [MinuteW-1:0] on_m;
    logic [HourW-1:0]  off_h;
    logic [MinuteW-1:0] off_m;
    logic [RampW-1:0]  ramp_len;
    logic [LevelW-1:0] slew;
    int unsigned       level_now;

    dlds_pkg::out_word_t level_queue[$];
    int          errors;
    bit          idle_on;
    int          burst_left;
    int          gap_max;
    int          stall_pct;
    int          hold_request;
    int unsigned walk_min;

    daily_light_dimming_scheduler DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #5ms;
        $display("tb_daily_light_dimming_scheduler: errors");
        $finish;
    end

    function automatic int unsigned window_target(logic [HourW-1:0] h, logic [MinuteW-1:0] m);
        int unsigned now;
        int unsigned t_on;
        int unsigned t_off;
        int unsigned span;
        int unsigned el;
        if (!sch_en)
            return 0;
        now   = (int'(h) * MinPerHour + int'(m)) % MinPerDay;
        t_on  = int'(on_h) * MinPerHour + int'(on_m);
        t_off = int'(off_h) * MinPerHour + int'(off_m);
        span  = (t_off + MinPerDay - t_on) % MinPerDay;
        el    = (now + MinPerDay - t_on) % MinPerDay;
        if (el >= span)
            return 0;
        if (span <= 2 * int'(ramp_len))
            return FullLevel;
        if (el < ramp_len)
            return el * FullLevel / ramp_len;
        if (el < span - ramp_len)
            return FullLevel;
        return (span - el) * FullLevel / ramp_len;
    endfunction

    function automatic dlds_pkg::out_word_t predict_word(dlds_pkg::in_word_t tick);
        int unsigned         tgt;
        dlds_pkg::out_word_t w;
        tgt = window_target(tick.hour, tick.minute);
        if (tgt > level_now)
            level_now = (tgt - level_now > slew) ? level_now + slew : tgt;
        else if (level_now > tgt)
            level_now = (level_now - tgt > slew) ? level_now - slew : tgt;
        level_now  = level_now & 8'hFF;
        w.level    = level_now[LevelW-1:0];
        w.light_on = (level_now != 0);
        return w;
    endfunction

    function automatic void apply_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
        case (idx)
            dlds_pkg::CFG_ENABLE:
            begin
                sch_en = d[0];
                if (!d[0])
                    level_now = 0;
            end
            dlds_pkg::CFG_ON_HOUR:    on_h     = HourW'(d[HourW-1:0] % HoursPerDay);
            dlds_pkg::CFG_ON_MINUTE:  on_m     = MinuteW'(d[MinuteW-1:0] % MinPerHour);
            dlds_pkg::CFG_OFF_HOUR:   off_h    = HourW'(d[HourW-1:0] % HoursPerDay);
            dlds_pkg::CFG_OFF_MINUTE: off_m    = MinuteW'(d[MinuteW-1:0] % MinPerHour);
            dlds_pkg::CFG_RAMP:       ramp_len = d[RampW-1:0];
            dlds_pkg::CFG_STEP:       slew     = d[LevelW-1:0];
            default:                  ;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $realtime, what);
        errors++;
    endtask

    task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input int d);
        logic [CfgDataW-1:0] v;
        v = CfgDataW'(d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        apply_cfg(idx, v);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_schedule(input int en, input int onh, input int onm, input int offh,
                                input int offm, input int ramp, input int step);
        cfg_write(dlds_pkg::CFG_ON_HOUR, onh);
        cfg_write(dlds_pkg::CFG_ON_MINUTE, onm);
        cfg_write(dlds_pkg::CFG_OFF_HOUR, offh);
        cfg_write(dlds_pkg::CFG_OFF_MINUTE, offm);
        cfg_write(dlds_pkg::CFG_RAMP, ramp);
        cfg_write(dlds_pkg::CFG_STEP, step);
        cfg_write(dlds_pkg::CFG_ENABLE, en);
    endtask

    task automatic send_tick(input int h, input int m);
        dlds_pkg::in_word_t tick;
        tick.hour   = HourW'(h);
        tick.minute = MinuteW'(m);
        in_valid <= 1'b1;
        in_data  <= tick;
        do @(posedge clk); while (in_stall);
        level_queue.push_back(predict_word(tick));
        if (idle_on)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
                burst_left = $urandom_range(0, 12);
            end
            else
                burst_left--;
        end
    endtask

    task automatic wait_idle();
        @(posedge clk);
        in_valid <= 1'b0;
        while (level_queue.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic send_picked(input int mode);
        int unsigned base;
        int          reach;
        int          t;
        if (mode == PickRaw || $urandom_range(0, 4) == 0)
        begin
            send_tick(int'($urandom_range(0, 31)), int'($urandom_range(0, 63)));
            return;
        end
        reach = (ramp_len > 720) ? 720 : int'(ramp_len);
        if (mode == PickEdge)
        begin
            base = $urandom_range(0, 1) ? on_h * MinPerHour + on_m : off_h * MinPerHour + off_m;
            t = (int'(base) + 2 * MinPerDay + $urandom_range(0, 2 * reach + 4) - (reach + 2))
                % MinPerDay;
        end
        else
        begin
            walk_min = (walk_min + $urandom_range(0, reach / 8 + 2)) % MinPerDay;
            t = walk_min;
        end
        send_tick(t / MinPerHour, t % MinPerHour);
    endtask

    task automatic test_reset_state();
        send_tick(0, 0);
        send_tick(31, 63);
        wait_idle();
        cfg_write(dlds_pkg::CFG_ENABLE, 1);
        send_tick(12, 0);
        wait_idle();
    endtask

    task automatic test_day_window();
        set_schedule(1, 6, 0, 22, 0, 30, 255);
        send_tick(5, 59);
        send_tick(6, 0);
        send_tick(6, 1);
        send_tick(6, 29);
        send_tick(6, 30);
        send_tick(12, 0);
        send_tick(21, 30);
        send_tick(21, 31);
        send_tick(21, 59);
        send_tick(22, 0);
        wait_idle();
    endtask

    task automatic test_overnight_window();
        set_schedule(1, 22, 30, 5, 15, 60, 255);
        send_tick(23, 0);
        send_tick(0, 0);
        send_tick(24, 10);
        send_tick(5, 14);
        send_tick(31, 63);
        wait_idle();
    endtask

    task automatic test_corner_settings();
        set_schedule(1, 31, 63, 8, 0, 0, 255);
        send_tick(7, 3);
        send_tick(7, 59);
        wait_idle();
        cfg_write(dlds_pkg::CFG_RAMP, 1023);
        send_tick(7, 30);
        wait_idle();
        cfg_write(dlds_pkg::CFG_STEP, 0);
        send_tick(9, 0);
        wait_idle();
        cfg_write(dlds_pkg::CFG_STEP, 1);
        send_tick(9, 0);
        wait_idle();
        cfg_write(CfgUnused, 1023);
        send_tick(9, 0);
        wait_idle();
        cfg_write(dlds_pkg::CFG_ENABLE, 0);
        send_tick(7, 30);
        wait_idle();
        set_schedule(1, 10, 20, 10, 20, 720, 255);
        send_tick(10, 20);
        send_tick(15, 0);
        wait_idle();
    endtask

    task automatic random_schedule();
        int ramp;
        int step;
        int onh;
        int onm;
        case ($urandom_range(0, 5))
            0:       ramp = 0;
            1:       ramp = 1;
            2:       ramp = 720;
            3:       ramp = int'($urandom_range(721, 1023));
            default: ramp = int'($urandom_range(2, 120));
        endcase
        case ($urandom_range(0, 9))
            0:       step = 0;
            1:       step = 1;
            2:       step = 255;
            default: step = int'($urandom_range(1, 64));
        endcase
        onh = int'($urandom_range(0, 31));
        onm = int'($urandom_range(0, 63));
        if ($urandom_range(0, 9) == 0)
            set_schedule(int'($urandom_range(0, 9) != 0), onh, onm, onh, onm, ramp, step);
        else
            set_schedule(int'($urandom_range(0, 9) != 0), onh, onm,
                         int'($urandom_range(0, 31)), int'($urandom_range(0, 63)), ramp, step);
    endtask

    task automatic test_random_ticks();
        int mode;
        for (int phase = 0; phase < 12; phase++)
        begin
            random_schedule();
            idle_on   = (phase % 4) != 3;
            stall_pct = ((phase % 4) == 2) ? 0 : $urandom_range(10, 60);
            gap_max   = $urandom_range(1, 20);
            walk_min  = $urandom_range(0, MinPerDay - 1);
            case (phase % 3)
                0:       mode = PickRaw;
                1:       mode = PickEdge;
                default: mode = PickWalk;
            endcase
            for (int i = 0; i < 50; i++)
                send_picked(mode);
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        set_schedule(1, 8, 0, 20, 0, 45, 7);
        idle_on      = 1'b0;
        hold_request = 300;
        for (int i = 0; i < 20; i++)
            send_picked(PickEdge);
        wait_idle();
        idle_on = 1'b1;
    endtask

    initial
    begin : receiver
        int stall_run;
        int hold_len;
        stall_run = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_len     = hold_request;
                hold_request = 0;
                out_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (stall_run == 0)
            begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
                stall_run = $urandom_range(1, 8);
            end
            else
                stall_run--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (level_queue.size() == 0)
                report_mismatch("output word with no tick pending");
            else
            begin
                if (out_data.level !== level_queue[0].level)
                    report_mismatch($sformatf("level %0d, predicted %0d",
                                              out_data.level, level_queue[0].level));
                if (out_data.light_on !== level_queue[0].light_on)
                    report_mismatch($sformatf("light_on %0b, predicted %0b",
                                              out_data.light_on, level_queue[0].light_on));
                void'(level_queue.pop_front());
            end
        end
    end

    initial
    begin : main
        int waited;
        errors       = 0;
        idle_on      = 1'b1;
        burst_left   = 0;
        gap_max      = 6;
        stall_pct    = 25;
        hold_request = 0;
        walk_min     = 0;
        sch_en       = 1'b0;
        on_h         = '0;
        on_m         = '0;
        off_h        = '0;
        off_m        = '0;
        ramp_len     = dlds_pkg::RampReset;
        slew         = dlds_pkg::StepReset;
        level_now    = 0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_day_window();
        test_overnight_window();
        test_corner_settings();
        test_backpressure();
        test_random_ticks();

        @(posedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (level_queue.size() != 0 && waited < DrainLimit)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SettleCycles) @(posedge clk);
        if (level_queue.size() != 0)
            report_mismatch($sformatf("%0d ticks never produced a word", level_queue.size()));

        if (errors == 0)
            $display("tb_daily_light_dimming_scheduler: clean");
        else
            $display("tb_daily_light_dimming_scheduler: errors");
        $finish;
    end

endmodule
